>>> src/lrw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrw_pkg
// Shared types, codes and constants of the lattice random walk statistics block.
// ----------------------------------------------------------------------------
package lrw_pkg;

	// Sizes of the accumulator store and story counting
	localparam int MAX_STEPS   = 16384;
	localparam int MAX_STORIES = 65536;
	localparam int ACC_DEPTH   = MAX_STEPS;
	localparam int ACC_IDX_W   = $clog2(ACC_DEPTH);
	localparam int FILL_W      = ACC_IDX_W + 1;

	// Field widths
	localparam int STEP_W      = 14;
	localparam int STEPS_CFG_W = 15;
	localparam int STORY_W     = 17;
	localparam int POS_W       = 16;
	localparam int SUM_W       = 31;
	localparam int SQ_W        = 45;
	localparam int ACC_OUT_W   = 32;
	localparam int GEN_W       = 64;
	localparam int HALF_W      = GEN_W / 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEPS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

	// Commands
	localparam logic CMD_STEP = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Move directions from the top two generator bits
	localparam logic [1:0] DIR_POS_X = 2'd0;
	localparam logic [1:0] DIR_POS_Y = 2'd1;
	localparam logic [1:0] DIR_NEG_X = 2'd2;
	localparam logic [1:0] DIR_NEG_Y = 2'd3;

	// Generator multiplier and its square, both modulo 2^64
	localparam logic [GEN_W-1:0] LCG_MUL  = 64'd1181783497276652981;
	localparam logic [GEN_W-1:0] LCG_MUL2 = GEN_W'(LCG_MUL * LCG_MUL);
	localparam logic [GEN_W-1:0] RST_SEED = 64'd1;

	// Register reset values and clamps
	localparam logic [STEPS_CFG_W-1:0] RST_STEPS = 15'd10000;
	localparam logic [STORY_W-1:0]     RST_LIMIT = 17'd10000;
	localparam logic [STEPS_CFG_W-1:0] STEPS_CAP = STEPS_CFG_W'(MAX_STEPS);
	localparam logic [STORY_W-1:0]     LIMIT_CAP = STORY_W'(MAX_STORIES);

	typedef enum logic [1:0] {
		GEN_RUN,
		GEN_MUL_A,
		GEN_SUM_A,
		GEN_MUL_B
	} gen_state_t;

	typedef struct packed {
		logic                 cmd;
		logic [STEP_W-1:0]    read_index;
	} lrw_in_t;

	typedef struct packed {
		logic signed [POS_W-1:0]     walker_x;
		logic signed [POS_W-1:0]     walker_y;
		logic [STEP_W-1:0]           step_number;
		logic [STORY_W-1:0]          stories_done;
		logic signed [ACC_OUT_W-1:0] acc_sum_x;
		logic signed [ACC_OUT_W-1:0] acc_sum_y;
		logic [SQ_W-1:0]             acc_sumsq_x;
		logic [SQ_W-1:0]             acc_sumsq_y;
		logic                        limit_reached;
	} lrw_out_t;

	// One accumulator store word
	typedef struct packed {
		logic [SUM_W-1:0] sum_x;
		logic [SUM_W-1:0] sum_y;
		logic [SQ_W-1:0]  sq_x;
		logic [SQ_W-1:0]  sq_y;
	} lrw_acc_t;

	// Request from the walk control to the statistics store
	typedef struct packed {
		logic                    go;
		logic                    wr;
		logic [ACC_IDX_W-1:0]    idx;
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
	} lrw_acc_req_t;

endpackage

>>> src/lattice_random_walk_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_random_walk_statistics
// Random walk on a 2D lattice with per-step-index sums of x, y, x^2 and y^2.
// A beat passes stage one, then the response register. Throughput: one beat
// per cycle while rsp_ready keeps up, set by the store's read-modify-write
// loop. A seed write holds req_ready low while the generator refills.
// Reset: walker at origin, counters zero, store reads as zero at once.
// ----------------------------------------------------------------------------
module lattice_random_walk_statistics
	import lrw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  lrw_in_t               req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output lrw_out_t              rsp
);

	// Effective configuration: clamps are applied as the value is written,
	// so steps_per_story of zero is stored as one and large values as caps.
	logic [STEPS_CFG_W-1:0]  steps_eff_q;
	logic [STORY_W-1:0]      limit_eff_q;

	// Walker state
	logic signed [POS_W-1:0] pos_x_q, pos_y_q;
	logic [STEP_W-1:0]       step_q;
	logic [STORY_W-1:0]      story_q;

	// Pipeline and response register
	logic                    vld_s1;
	lrw_out_t                rsp_s1;
	logic                    rsp_v_q;
	lrw_out_t                rsp_q;
	lrw_out_t                rsp_d;

	logic                    accept, s1_adv, seed_load;
	logic                    gen_busy;
	logic [1:0]              gen_dir;
	logic                    limit_hit, is_step, wrap;
	logic signed [POS_W-1:0] mv_x, mv_y, nxt_x, nxt_y;
	logic [STEPS_CFG_W-1:0]  cnt_inc;
	logic [STEP_W-1:0]       nxt_step;
	logic [STORY_W-1:0]      nxt_story;
	lrw_acc_req_t            acc_req;
	lrw_acc_t                acc_res;

	// Handshake: the stage ahead frees up when the response register is
	// empty or is being taken in the same cycle.
	assign s1_adv    = vld_s1 && (!rsp_v_q || rsp_ready);
	assign req_ready = !gen_busy && (!vld_s1 || s1_adv);
	assign accept    = req_valid && req_ready;
	assign seed_load = cfg_wr_en && (cfg_index == CFG_SEED);

	// Step decision and next walker state, all from the current registers.
	always_comb begin
		limit_hit = story_q >= limit_eff_q;
		is_step   = (req.cmd == CMD_STEP) && !limit_hit;
		mv_x = pos_x_q;
		mv_y = pos_y_q;
		case (gen_dir)
			DIR_POS_X: mv_x = pos_x_q + 16'sd1;
			DIR_POS_Y: mv_y = pos_y_q + 16'sd1;
			DIR_NEG_X: mv_x = pos_x_q - 16'sd1;
			DIR_NEG_Y: mv_y = pos_y_q - 16'sd1;
			default:   mv_y = pos_y_q;
		endcase
		cnt_inc   = {1'b0, step_q} + 15'd1;
		wrap      = cnt_inc >= steps_eff_q;
		nxt_x     = pos_x_q;
		nxt_y     = pos_y_q;
		nxt_step  = step_q;
		nxt_story = story_q;
		if (is_step) begin
			if (wrap) begin
				// end of story: back to the origin
				nxt_x     = '0;
				nxt_y     = '0;
				nxt_step  = '0;
				nxt_story = story_q + 17'd1;
			end else begin
				nxt_x    = mv_x;
				nxt_y    = mv_y;
				nxt_step = cnt_inc[STEP_W-1:0];
			end
		end
	end

	// Store access: a read beat looks up its index, a step (taken or
	// ignored) the current step index. Sums take the position after the
	// move, before any return to the origin.
	always_comb begin
		acc_req.go  = accept;
		acc_req.wr  = is_step;
		acc_req.idx = (req.cmd == CMD_READ) ? req.read_index : step_q;
		acc_req.px  = mv_x;
		acc_req.py  = mv_y;
	end

	lrw_gen u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_load (seed_load),
		.seed      (cfg_data),
		.adv       (accept && is_step),
		.dir       (gen_dir),
		.busy      (gen_busy)
	);

	lrw_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (acc_req),
		.adv    (s1_adv),
		.res    (acc_res)
	);

	// Configuration and walker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_eff_q <= RST_STEPS;
			limit_eff_q <= RST_LIMIT;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			step_q      <= '0;
			story_q     <= '0;
		end else begin
			if (cfg_wr_en && (cfg_index == CFG_STEPS)) begin
				if (cfg_data[STEPS_CFG_W-1:0] == '0) begin
					steps_eff_q <= 15'd1;
				end else if (cfg_data[STEPS_CFG_W-1:0] > STEPS_CAP) begin
					steps_eff_q <= STEPS_CAP;
				end else begin
					steps_eff_q <= cfg_data[STEPS_CFG_W-1:0];
				end
			end
			if (cfg_wr_en && (cfg_index == CFG_LIMIT)) begin
				if (cfg_data[STORY_W-1:0] > LIMIT_CAP) begin
					limit_eff_q <= LIMIT_CAP;
				end else begin
					limit_eff_q <= cfg_data[STORY_W-1:0];
				end
			end
			if (accept && is_step) begin
				pos_x_q <= nxt_x;
				pos_y_q <= nxt_y;
				step_q  <= nxt_step;
				story_q <= nxt_story;
			end
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			rsp_v_q <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				vld_s1 <= 1'b0;
			end
			if (s1_adv) begin
				rsp_v_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_v_q <= 1'b0;
			end
		end
	end

	// Merge the sums from the store into the walker fields of stage one.
	always_comb begin
		rsp_d             = rsp_s1;
		rsp_d.acc_sum_x   = {acc_res.sum_x[SUM_W-1], acc_res.sum_x};
		rsp_d.acc_sum_y   = {acc_res.sum_y[SUM_W-1], acc_res.sum_y};
		rsp_d.acc_sumsq_x = acc_res.sq_x;
		rsp_d.acc_sumsq_y = acc_res.sq_y;
	end

	// Payload: walker fields are known at accept, sums come from the store in stage one.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_s1.walker_x      <= nxt_x;
			rsp_s1.walker_y      <= nxt_y;
			rsp_s1.step_number   <= nxt_step;
			rsp_s1.stories_done  <= nxt_story;
			rsp_s1.acc_sum_x     <= '0;
			rsp_s1.acc_sum_y     <= '0;
			rsp_s1.acc_sumsq_x   <= '0;
			rsp_s1.acc_sumsq_y   <= '0;
			rsp_s1.limit_reached <= nxt_story >= limit_eff_q;
		end
		if (s1_adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;

endmodule

>>> src/lrw_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrw_gen
// Multiplicative 64-bit generator with one step of lookahead: two chains
// interleave through a two-register loop that multiplies by the square.
// ----------------------------------------------------------------------------
module lrw_gen
	import lrw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             seed_load,
	input  logic [GEN_W-1:0] seed,
	input  logic             adv,
	output logic [1:0]       dir,
	output logic             busy
);

	gen_state_t        st_q, st_nxt;
	logic [GEN_W-1:0]  nxt_q;
	logic [GEN_W-1:0]  pp0_q;
	logic [HALF_W-1:0] pp1_q, pp2_q;
	logic              pp_ld, sum_ld, use_c1;
	logic [GEN_W-1:0]  mul_k;
	logic [GEN_W-1:0]  m0;
	logic [HALF_W-1:0] m1, m2, hi_sum;
	logic [GEN_W-1:0]  sum;

	// next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			GEN_MUL_A: st_nxt = GEN_SUM_A;
			GEN_SUM_A: st_nxt = GEN_MUL_B;
			GEN_MUL_B: st_nxt = GEN_RUN;
			GEN_RUN:   st_nxt = GEN_RUN;
			default:   st_nxt = GEN_RUN;
		endcase
		if (seed_load) begin
			st_nxt = GEN_MUL_A;
		end
	end

	// outputs
	always_comb begin
		pp_ld  = 1'b0;
		sum_ld = 1'b0;
		use_c1 = 1'b0;
		busy   = 1'b1;
		case (st_q)
			GEN_MUL_A: begin
				pp_ld  = 1'b1;
				use_c1 = 1'b1;
			end
			GEN_SUM_A: sum_ld = 1'b1;
			GEN_MUL_B: begin
				pp_ld  = 1'b1;
				use_c1 = 1'b1;
			end
			GEN_RUN: begin
				busy   = 1'b0;
				pp_ld  = adv;
				sum_ld = adv;
			end
			default: busy = 1'b1;
		endcase
	end

	// partial products of the low 64 bits of nxt_q * k
	always_comb begin
		mul_k  = use_c1 ? LCG_MUL : LCG_MUL2;
		m0     = {{HALF_W{1'b0}}, nxt_q[HALF_W-1:0]} *
			{{HALF_W{1'b0}}, mul_k[HALF_W-1:0]};
		m1     = nxt_q[HALF_W-1:0] * mul_k[GEN_W-1:HALF_W];
		m2     = nxt_q[GEN_W-1:HALF_W] * mul_k[HALF_W-1:0];
		hi_sum = pp1_q + pp2_q;
		sum    = pp0_q + {hi_sum, {HALF_W{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= GEN_RUN;
			nxt_q <= LCG_MUL;
			pp0_q <= LCG_MUL2;
			pp1_q <= '0;
			pp2_q <= '0;
		end else begin
			st_q <= st_nxt;
			if (seed_load) begin
				nxt_q <= seed;
			end else begin
				if (sum_ld) begin
					nxt_q <= sum;
				end
				if (pp_ld) begin
					pp0_q <= m0;
					pp1_q <= m1;
					pp2_q <= m2;
				end
			end
		end
	end

	assign dir = nxt_q[GEN_W-1:GEN_W-2];

endmodule

>>> src/lrw_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrw_stats
// Per-step accumulator store: read at accept; for a step, add and write back
// when the request leaves stage one, with forwarding of the word being written.
// ----------------------------------------------------------------------------
module lrw_stats
	import lrw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  lrw_acc_req_t req,
	input  logic         adv,
	output lrw_acc_t     res
);

	lrw_acc_t                acc_mem [ACC_DEPTH];
	lrw_acc_t                rdata_s1;
	lrw_acc_t                fwd_word_s1;
	logic                    fwd_s1, hit_s1, wr_s1;
	logic [ACC_IDX_W-1:0]    idx_s1;
	logic signed [POS_W-1:0] px_s1, py_s1;
	logic [FILL_W-1:0]       fill_q;
	logic                    wr_en, fwd_hit;
	lrw_acc_t                old_word, new_word;
	logic [2*POS_W-1:0]      sqx, sqy;

	assign wr_en   = adv && wr_s1;
	assign fwd_hit = wr_en && (idx_s1 == req.idx);

	always_comb begin
		if (fwd_s1) begin
			old_word = fwd_word_s1;
		end else if (hit_s1) begin
			old_word = rdata_s1;
		end else begin
			old_word = '0;
		end
		sqx = $unsigned((2*POS_W)'(px_s1) * (2*POS_W)'(px_s1));
		sqy = $unsigned((2*POS_W)'(py_s1) * (2*POS_W)'(py_s1));
		new_word.sum_x = old_word.sum_x + SUM_W'(px_s1);
		new_word.sum_y = old_word.sum_y + SUM_W'(py_s1);
		new_word.sq_x  = old_word.sq_x + {{(SQ_W-2*POS_W){1'b0}}, sqx};
		new_word.sq_y  = old_word.sq_y + {{(SQ_W-2*POS_W){1'b0}}, sqy};
		res = wr_s1 ? new_word : old_word;
	end

	// store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			acc_mem[idx_s1] <= new_word;
		end
		if (req.go) begin
			rdata_s1 <= acc_mem[req.idx];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (req.go) begin
			idx_s1      <= req.idx;
			wr_s1       <= req.wr;
			px_s1       <= req.px;
			py_s1       <= req.py;
			fwd_s1      <= fwd_hit;
			fwd_word_s1 <= new_word;
			hit_s1      <= {1'b0, req.idx} < fill_q;
		end
	end

	// written entries always form a prefix; track its length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (wr_en && ({1'b0, idx_s1} == fill_q)) begin
			fill_q <= fill_q + 1'b1;
		end
	end

endmodule

>>> src/lrw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrw_checker
// Port-level checks of the lattice random walk statistics block.
// ----------------------------------------------------------------------------
module lrw_checker
	import lrw_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_wr_en,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input lrw_out_t              rsp
);

	// stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// at the start of a story the walker sits at the origin
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.step_number == '0) |->
			(rsp.walker_x == '0) && (rsp.walker_y == '0))
		else $error("walker off origin at step zero");

	// each step flips the parity of x + y
	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.walker_x[0] ^ rsp.walker_y[0]) == rsp.step_number[0]))
		else $error("walker parity does not match step number");

	// a new response follows a request beat through stage one and the response register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("response without request beat");

	// generator refill blocks requests after a seed write
	a_seed_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en && (cfg_index == CFG_SEED) |=> !req_ready)
		else $error("request taken during generator refill");

endmodule

bind lattice_random_walk_statistics lrw_checker u_lrw_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice random walk statistics testbench
// Drives step and read beats into the walk engine under random bursts and
// random output stalls. An in-bench copy of the walk predicts every response
// beat, and each one is compared field by field in order. It covers the
// register extremes and story limits, and a long output hold that backs up
// the request side.
// ----------------------------------------------------------------------------
module testbench;
	import lrw_pkg::*;

	localparam logic [63:0] WALK_MUL   = 64'd1181783497276652981;
	localparam int          STEP_SLOTS = 16384;
	localparam int          STORY_CAP  = 65536;
	localparam int          WALK_ITEMS = 1500;

	// Expected-response tracker: keeps its own walk, generator and sums
	class walk_tracker;
		logic [63:0]       gen;
		logic [14:0]       steps_reg;
		logic [16:0]       limit_reg;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		int unsigned       step_idx;
		int unsigned       story_cnt;
		logic [30:0]       sum_x_mem [STEP_SLOTS];
		logic [30:0]       sum_y_mem [STEP_SLOTS];
		logic [44:0]       sq_x_mem [STEP_SLOTS];
		logic [44:0]       sq_y_mem [STEP_SLOTS];
		lrw_out_t          walk_outcomes[$];
		int                errors;
		int                checked;

		function new();
			gen       = 64'd1;
			steps_reg = 15'd10000;
			limit_reg = 17'd10000;
			pos_x     = '0;
			pos_y     = '0;
			step_idx  = 0;
			story_cnt = 0;
			errors    = 0;
			checked   = 0;
			for (int i = 0; i < STEP_SLOTS; i++) begin
				sum_x_mem[i] = '0;
				sum_y_mem[i] = '0;
				sq_x_mem[i]  = '0;
				sq_y_mem[i]  = '0;
			end
		endfunction

		function int unsigned eff_steps();
			if (steps_reg == 0)
				return 1;
			if (steps_reg > STEP_SLOTS)
				return STEP_SLOTS;
			return 32'(steps_reg);
		endfunction

		function int unsigned eff_limit();
			if (limit_reg > STORY_CAP)
				return STORY_CAP;
			return 32'(limit_reg);
		endfunction

		function bit limited();
			return story_cnt >= eff_limit();
		endfunction

		function int pending();
			return walk_outcomes.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
			case (idx)
				CFG_SEED:  gen = data;
				CFG_STEPS: steps_reg = data[14:0];
				CFG_LIMIT: limit_reg = data[16:0];
				default: ;
			endcase
		endfunction

		// Take one request beat (a step advances the walk) and queue the response it owes
		function void note_request(lrw_in_t item);
			lrw_out_t           r;
			logic [13:0]        idx;
			logic signed [31:0] px;
			logic signed [31:0] py;
			logic signed [31:0] sqx;
			logic signed [31:0] sqy;
			if (item.cmd == CMD_READ) begin
				idx = item.read_index;
			end else begin
				idx = step_idx[13:0];
				if (!limited()) begin
					gen = gen * WALK_MUL;
					case (gen[63:62])
						DIR_POS_X: pos_x = pos_x + 16'sd1;
						DIR_POS_Y: pos_y = pos_y + 16'sd1;
						DIR_NEG_X: pos_x = pos_x - 16'sd1;
						default:   pos_y = pos_y - 16'sd1;
					endcase
					px  = pos_x;
					py  = pos_y;
					sqx = px * px;
					sqy = py * py;
					sum_x_mem[idx] = sum_x_mem[idx] + px[30:0];
					sum_y_mem[idx] = sum_y_mem[idx] + py[30:0];
					sq_x_mem[idx]  = sq_x_mem[idx] + 45'(sqx);
					sq_y_mem[idx]  = sq_y_mem[idx] + 45'(sqy);
					step_idx++;
					// story over: walker back home, next story starts at index 0
					if (step_idx >= eff_steps()) begin
						step_idx = 0;
						story_cnt++;
						pos_x = '0;
						pos_y = '0;
					end
				end
			end
			r.walker_x      = pos_x;
			r.walker_y      = pos_y;
			r.step_number   = step_idx[13:0];
			r.stories_done  = story_cnt[16:0];
			r.acc_sum_x     = {sum_x_mem[idx][30], sum_x_mem[idx]};
			r.acc_sum_y     = {sum_y_mem[idx][30], sum_y_mem[idx]};
			r.acc_sumsq_x   = sq_x_mem[idx];
			r.acc_sumsq_y   = sq_y_mem[idx];
			r.limit_reached = limited();
			walk_outcomes.push_back(r);
		endfunction

		function void flag(string field, logic signed [63:0] want, logic signed [63:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_response(lrw_out_t got);
			lrw_out_t want;
			if (walk_outcomes.size() == 0) begin
				errors++;
				$display("%0t: response beat with nothing expected, actual %h", $time, got);
			end else begin
				want = walk_outcomes.pop_front();
				checked++;
				if (got.walker_x !== want.walker_x)
					flag("walker_x", 64'(want.walker_x), 64'(got.walker_x));
				if (got.walker_y !== want.walker_y)
					flag("walker_y", 64'(want.walker_y), 64'(got.walker_y));
				if (got.step_number !== want.step_number)
					flag("step_number", 64'(want.step_number), 64'(got.step_number));
				if (got.stories_done !== want.stories_done)
					flag("stories_done", 64'(want.stories_done), 64'(got.stories_done));
				if (got.acc_sum_x !== want.acc_sum_x)
					flag("acc_sum_x", 64'(want.acc_sum_x), 64'(got.acc_sum_x));
				if (got.acc_sum_y !== want.acc_sum_y)
					flag("acc_sum_y", 64'(want.acc_sum_y), 64'(got.acc_sum_y));
				if (got.acc_sumsq_x !== want.acc_sumsq_x)
					flag("acc_sumsq_x", 64'(want.acc_sumsq_x), 64'(got.acc_sumsq_x));
				if (got.acc_sumsq_y !== want.acc_sumsq_y)
					flag("acc_sumsq_y", 64'(want.acc_sumsq_y), 64'(got.acc_sumsq_y));
				if (got.limit_reached !== want.limit_reached)
					flag("limit_reached", 64'(want.limit_reached), 64'(got.limit_reached));
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	lrw_in_t               req       = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	lrw_out_t              rsp;

	walk_tracker sb;

	// Receiver stall state
	int stall_mode    = 0;
	int mode_left     = 0;
	int hold_left     = 0;
	int next_hold_at  = 400;

	lattice_random_walk_statistics uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	// Receiver: check each accepted response beat, then pick the next ready.
	// Stall pattern: always ready, coin flip, or mostly stalled, switched at
	// random. At 400 checked beats and every 700 more, hold off for a long
	// stretch so the engine fills up and pushes back on the request side.
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			sb.check_response(rsp);
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (sb.checked >= next_hold_at) begin
			hold_left    = $urandom_range(150, 250);
			next_hold_at = next_hold_at + 700;
			rsp_ready   <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(20, 120);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0:       rsp_ready <= 1'b1;
				1:       rsp_ready <= 1'($urandom_range(0, 1));
				default: rsp_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Safety net: a hung handshake ends the run here
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Offer one request beat and hold it until accepted
	task automatic offer_item(input lrw_in_t item);
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.note_request(item);
	endtask

	task automatic offer_step();
		lrw_in_t item;
		item.cmd        = CMD_STEP;
		item.read_index = 14'($urandom_range(0, STEP_SLOTS - 1));
		offer_item(item);
	endtask

	task automatic offer_read(input int unsigned idx);
		lrw_in_t item;
		item.cmd        = CMD_READ;
		item.read_index = idx[13:0];
		offer_item(item);
	endtask

	// Drop valid and wait until every owed response beat has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Reprogram the engine while it is idle
	task automatic program_regs(input bit wr_seed, input logic [63:0] seed_v,
			input bit wr_steps, input logic [63:0] steps_v,
			input bit wr_limit, input logic [63:0] limit_v);
		wait_drained();
		if (wr_seed)
			write_reg(CFG_SEED, seed_v);
		if (wr_steps)
			write_reg(CFG_STEPS, steps_v);
		if (wr_limit)
			write_reg(CFG_LIMIT, limit_v);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		lrw_in_t     item;
		logic [63:0] junk;
		logic [63:0] seed_v;
		logic [63:0] steps_v;
		logic [63:0] limit_v;
		bit          wr_seed;
		int unsigned pick;
		int unsigned stories;
		int          walk_items;
		int          phase_len;
		int          burst_left;

		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: power-on values, clamps, limits and mid-story changes
		offer_read(0);
		offer_read(STEP_SLOTS - 1);
		offer_step();
		offer_step();
		offer_step();
		offer_read(0);

		// zero steps per story acts as one; limit of two with junk above
		junk = {$urandom, $urandom};
		program_regs(1'b0, '0, 1'b1, {junk[63:15], 15'd0}, 1'b1, {junk[63:17], 17'd2});
		offer_step();
		offer_step();
		offer_step();
		offer_read(0);

		// zero seed walks only +x; limit above the cap
		program_regs(1'b1, 64'd0, 1'b1, 64'd3, 1'b1, 64'd131071);
		repeat (4) offer_step();

		// limit of zero ignores every step
		program_regs(1'b0, '0, 1'b0, '0, 1'b1, 64'd0);
		offer_step();
		offer_step();

		// all-ones seed, steps above the cap, limit at the cap
		program_regs(1'b1, '1, 1'b1, 64'd32767, 1'b1, 64'd65536);
		offer_step();
		offer_step();
		offer_read(STEP_SLOTS - 1);
		offer_read(1);

		// lower steps per story twice in mid-story
		program_regs(1'b0, '0, 1'b1, 64'd5, 1'b0, '0);
		repeat (3) offer_step();
		program_regs(1'b0, '0, 1'b1, 64'd2, 1'b0, '0);
		offer_step();
		offer_step();

		// Random phases: mostly short stories with a reachable limit
		walk_items = 0;
		while (walk_items < WALK_ITEMS) begin
			junk    = {$urandom, $urandom};
			stories = sb.story_cnt;

			pick    = $urandom_range(0, 99);
			wr_seed = (pick < 70);
			if (pick < 5)
				seed_v = '0;
			else if (pick < 10)
				seed_v = '1;
			else
				seed_v = {$urandom, $urandom};

			pick = $urandom_range(0, 99);
			if (pick < 60)
				steps_v = 64'($urandom_range(1, 6));
			else if (pick < 85)
				steps_v = 64'($urandom_range(7, 60));
			else if (pick < 90)
				steps_v = '0;
			else if (pick < 95)
				steps_v = 64'($urandom_range(STEP_SLOTS + 1, 32767));
			else
				steps_v = 64'(STEP_SLOTS);
			if ($urandom_range(0, 1))
				steps_v = {junk[63:15], steps_v[14:0]};

			pick = $urandom_range(0, 99);
			if (pick < 70)
				limit_v = 64'(stories + $urandom_range(1, 20));
			else if (pick < 80)
				limit_v = 64'($urandom_range(STORY_CAP, 131071));
			else if (pick < 85)
				limit_v = 64'(STORY_CAP);
			else if (pick < 90)
				limit_v = '0;
			else if (pick < 95)
				limit_v = (stories == 0) ? '0 : 64'($urandom_range(0, stories));
			else
				limit_v = 64'($urandom_range(0, 131071));
			if ($urandom_range(0, 1))
				limit_v = {junk[48:2], limit_v[16:0]};

			program_regs(wr_seed, seed_v, 1'b1, steps_v, 1'b1, limit_v);

			phase_len  = $urandom_range(40, 160);
			burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
			for (int n = 0; n < phase_len; n++) begin
				if ($urandom_range(0, 3) == 0) begin
					item.cmd = CMD_READ;
					if ($urandom_range(0, 1))
						item.read_index = 14'($urandom_range(0, sb.eff_steps() - 1));
					else
						item.read_index = 14'($urandom_range(0, STEP_SLOTS - 1));
				end else begin
					item.cmd        = CMD_STEP;
					item.read_index = 14'($urandom_range(0, STEP_SLOTS - 1));
				end
				walk_items++;
				offer_item(item);
				burst_left--;
				// burst over: drop valid for a random gap
				if (burst_left == 0) begin
					req_valid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
					burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
				end
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
